// File: design/sqlts_pkg.sv
// Package for the SQL token scanner: request/token types, token kinds, keyword table.
package sqlts_pkg;

  // Width of the internal offset/line/column counters
  localparam int LOCATION_BITS = 32;
  typedef logic [LOCATION_BITS-1:0] loc_t;

  // Token kinds
  localparam logic [5:0] K_END           = 6'd0;
  localparam logic [5:0] K_IDENT         = 6'd1;
  localparam logic [5:0] K_INTEGER       = 6'd2;
  localparam logic [5:0] K_STRING        = 6'd3;
  localparam logic [5:0] K_INVALID       = 6'd4;
  localparam logic [5:0] K_PLUS          = 6'd5;
  localparam logic [5:0] K_MINUS         = 6'd6;
  localparam logic [5:0] K_STAR          = 6'd7;
  localparam logic [5:0] K_SLASH         = 6'd8;
  localparam logic [5:0] K_EQUAL         = 6'd9;
  localparam logic [5:0] K_NOT_EQUAL     = 6'd10;
  localparam logic [5:0] K_LESS          = 6'd11;
  localparam logic [5:0] K_LESS_EQUAL    = 6'd12;
  localparam logic [5:0] K_GREATER       = 6'd13;
  localparam logic [5:0] K_GREATER_EQUAL = 6'd14;
  localparam logic [5:0] K_LPAREN        = 6'd15;
  localparam logic [5:0] K_RPAREN        = 6'd16;
  localparam logic [5:0] K_COMMA         = 6'd17;
  localparam logic [5:0] K_DOT           = 6'd18;
  localparam logic [5:0] K_SEMICOLON     = 6'd19;
  localparam logic [5:0] K_KEYWORD_BASE  = 6'd20;
  localparam logic [5:0] K_COMMENT_ERROR = 6'd39;

  // Keywords, lowercase, first character in the top byte, zero padded to six bytes
  localparam int NUM_KEYWORDS = 19;
  localparam logic [47:0] KEYWORD_TEXT [NUM_KEYWORDS] = '{
    {"select"},        {"from", 16'h0},  {"where", 8'h0},  {"insert"},
    {"into", 16'h0},   {"values"},       {"create"},       {"table", 8'h0},
    {"drop", 16'h0},   {"null", 16'h0},  {"and", 24'h0},   {"or", 32'h0},
    {"not", 24'h0},    {"as", 32'h0},    {"order", 8'h0},  {"by", 32'h0},
    {"limit", 8'h0},   {"true", 16'h0},  {"false", 8'h0}
  };

  // Token queue depth (power of two), pointer and fill-count widths
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  typedef logic [QUEUE_PTR_BITS-1:0] qptr_t;
  typedef logic [QUEUE_PTR_BITS:0]   qcount_t;

  // One input request: a text byte or the end-of-text mark
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
  } byte_req_t;

  // One result token
  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic [31:0] start_line;
    logic [31:0] start_column;
    logic [31:0] end_line;
    logic [31:0] end_column;
    logic        last_of_run;
  } token_t;

  // Saturating counter step
  function automatic loc_t sat_inc(input loc_t v);
    sat_inc = (&v) ? v : v + loc_t'(1);
  endfunction

endpackage

// File: design/sql_token_scanner.sv
// Streaming SQL lexer: one text byte per request in, located tokens out.
// Takes one byte request per cycle while byte_ready is high and updates the scan state in
// the same cycle; the tokens a request produces (none, one or two) go into a four-entry
// token queue that drains one token per cycle while token_ready is high. byte_ready is
// high while the queue has at least two free slots, so with token_ready held high a
// stream of bytes is taken every cycle; a byte that closes one token and gives another
// pushes both, and a consumer stall backs up into byte_ready. An end_of_input request
// flushes the pending token, gives the end token (not after an unterminated block
// comment) and returns to the reset state. Offset, line and column counters are
// LOCATION_BITS wide and saturate; token fields carry their low 32 bits.
module sql_token_scanner (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  sqlts_pkg::byte_req_t byte_data,
  output logic                 token_valid,
  input  logic                 token_ready,
  output sqlts_pkg::token_t    token_data
);

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_NUMBER, M_STRING, M_STRING_QUOTE, M_MINUS, M_SLASH,
    M_BANG, M_LESS, M_GREATER, M_LINE_COMMENT, M_BLOCK, M_BLOCK_STAR
  } mode_t;

  // Scan state
  mode_t               mode, mode_next;
  logic [5:0][7:0]     prefix, prefix_next;
  logic [2:0]          wlen, wlen_next;
  sqlts_pkg::loc_t     cur_off, cur_line, cur_col;
  sqlts_pkg::loc_t     cur_off_next, cur_line_next, cur_col_next;
  sqlts_pkg::loc_t     tok_off, tok_line, tok_col;
  sqlts_pkg::loc_t     tok_off_next, tok_line_next, tok_col_next;

  // Token queue
  sqlts_pkg::token_t   queue [sqlts_pkg::QUEUE_DEPTH];
  sqlts_pkg::qptr_t    wr_ptr, rd_ptr;
  sqlts_pkg::qcount_t  count;

  // Step results
  logic [7:0]          b;
  logic [7:0]          lc;
  logic                is_alpha, is_digit, is_space;
  sqlts_pkg::loc_t     adv_off, adv_line, adv_col;
  logic [5:0]          word_kind;
  logic                redo;
  logic                a_valid, a_end_adv;
  logic [5:0]          a_kind;
  logic                b_valid, b_end_adv;
  logic [5:0]          b_kind;
  sqlts_pkg::token_t   tok_a, tok_b, res0, res1;
  logic [1:0]          push_n;
  logic                push, pop;

  assign b = byte_data.byte_value;

  // Character classes and cursor advance
  always_comb begin
    is_alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    is_digit = b >= "0" && b <= "9";
    is_space = b == " " || (b >= 8'd9 && b <= 8'd13);
    lc       = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    adv_off  = sqlts_pkg::sat_inc(cur_off);
    if (b == "\n") begin
      adv_line = sqlts_pkg::sat_inc(cur_line);
      adv_col  = sqlts_pkg::loc_t'(1);
    end else begin
      adv_line = cur_line;
      adv_col  = sqlts_pkg::sat_inc(cur_col);
    end
  end

  // Keyword match on the stored prefix
  always_comb begin
    word_kind = sqlts_pkg::K_IDENT;
    if (wlen <= 3'd6) begin
      for (int k = sqlts_pkg::NUM_KEYWORDS - 1; k >= 0; k--) begin
        if (prefix == sqlts_pkg::KEYWORD_TEXT[k]) begin
          word_kind = sqlts_pkg::K_KEYWORD_BASE + 6'(k);
        end
      end
    end
  end

  // Next state and the two result slots: A closes the pending token, B is from this byte
  always_comb begin
    mode_next     = mode;
    prefix_next   = prefix;
    wlen_next     = wlen;
    cur_off_next  = cur_off;
    cur_line_next = cur_line;
    cur_col_next  = cur_col;
    tok_off_next  = tok_off;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    redo          = 1'b0;
    a_valid       = 1'b0;
    a_end_adv     = 1'b0;
    a_kind        = sqlts_pkg::K_END;
    b_valid       = 1'b0;
    b_end_adv     = 1'b0;
    b_kind        = sqlts_pkg::K_END;

    if (byte_data.end_of_input) begin
      // Flush, end token unless a block comment is open, back to reset state
      a_valid = 1'b1;
      case (mode)
        M_WORD:         a_kind = word_kind;
        M_NUMBER:       a_kind = sqlts_pkg::K_INTEGER;
        M_STRING:       a_kind = sqlts_pkg::K_INVALID;
        M_STRING_QUOTE: a_kind = sqlts_pkg::K_STRING;
        M_MINUS:        a_kind = sqlts_pkg::K_MINUS;
        M_SLASH:        a_kind = sqlts_pkg::K_SLASH;
        M_BANG:         a_kind = sqlts_pkg::K_INVALID;
        M_LESS:         a_kind = sqlts_pkg::K_LESS;
        M_GREATER:      a_kind = sqlts_pkg::K_GREATER;
        M_BLOCK,
        M_BLOCK_STAR:   a_kind = sqlts_pkg::K_COMMENT_ERROR;
        default:        a_valid = 1'b0;
      endcase
      b_valid       = !(mode == M_BLOCK || mode == M_BLOCK_STAR);
      b_kind        = sqlts_pkg::K_END;
      mode_next     = M_IDLE;
      prefix_next   = '0;
      wlen_next     = '0;
      cur_off_next  = '0;
      cur_line_next = sqlts_pkg::loc_t'(1);
      cur_col_next  = sqlts_pkg::loc_t'(1);
      tok_off_next  = '0;
      tok_line_next = sqlts_pkg::loc_t'(1);
      tok_col_next  = sqlts_pkg::loc_t'(1);
    end else begin
      // Every text byte is consumed exactly once
      cur_off_next  = adv_off;
      cur_line_next = adv_line;
      cur_col_next  = adv_col;

      case (mode)
        M_WORD: begin
          if (is_alpha || is_digit) begin
            for (int i = 0; i < 6; i++) begin
              if (wlen == 3'(i)) prefix_next[5-i] = lc;
            end
            if (wlen != 3'd7) wlen_next = wlen + 3'd1;
          end else begin
            a_valid = 1'b1;
            a_kind  = word_kind;
            redo    = 1'b1;
          end
        end
        M_NUMBER: begin
          if (!is_digit) begin
            a_valid = 1'b1;
            a_kind  = sqlts_pkg::K_INTEGER;
            redo    = 1'b1;
          end
        end
        M_STRING: begin
          if (b == "'") mode_next = M_STRING_QUOTE;
        end
        M_STRING_QUOTE: begin
          if (b == "'") begin
            mode_next = M_STRING;
          end else begin
            a_valid = 1'b1;
            a_kind  = sqlts_pkg::K_STRING;
            redo    = 1'b1;
          end
        end
        M_MINUS: begin
          if (b == "-") begin
            mode_next = M_LINE_COMMENT;
          end else begin
            a_valid = 1'b1;
            a_kind  = sqlts_pkg::K_MINUS;
            redo    = 1'b1;
          end
        end
        M_SLASH: begin
          if (b == "*") begin
            mode_next = M_BLOCK;
          end else begin
            a_valid = 1'b1;
            a_kind  = sqlts_pkg::K_SLASH;
            redo    = 1'b1;
          end
        end
        M_BANG: begin
          a_valid = 1'b1;
          if (b == "=") begin
            a_kind    = sqlts_pkg::K_NOT_EQUAL;
            a_end_adv = 1'b1;
            mode_next = M_IDLE;
          end else begin
            a_kind = sqlts_pkg::K_INVALID;
            redo   = 1'b1;
          end
        end
        M_LESS: begin
          a_valid = 1'b1;
          if (b == "=" || b == ">") begin
            a_kind    = (b == "=") ? sqlts_pkg::K_LESS_EQUAL : sqlts_pkg::K_NOT_EQUAL;
            a_end_adv = 1'b1;
            mode_next = M_IDLE;
          end else begin
            a_kind = sqlts_pkg::K_LESS;
            redo   = 1'b1;
          end
        end
        M_GREATER: begin
          a_valid = 1'b1;
          if (b == "=") begin
            a_kind    = sqlts_pkg::K_GREATER_EQUAL;
            a_end_adv = 1'b1;
            mode_next = M_IDLE;
          end else begin
            a_kind = sqlts_pkg::K_GREATER;
            redo   = 1'b1;
          end
        end
        M_LINE_COMMENT: begin
          if (b == "\n") redo = 1'b1;
        end
        M_BLOCK: begin
          if (b == "*") mode_next = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          if (b == "/") mode_next = M_IDLE;
          else if (b != "*") mode_next = M_BLOCK;
        end
        default: redo = 1'b1;
      endcase

      // Handle the byte from the idle state
      if (redo) begin
        mode_next = M_IDLE;
        if (!is_space) begin
          tok_off_next  = cur_off;
          tok_line_next = cur_line;
          tok_col_next  = cur_col;
          if (is_alpha) begin
            prefix_next    = '0;
            prefix_next[5] = lc;
            wlen_next      = 3'd1;
            mode_next      = M_WORD;
          end else if (is_digit) begin
            mode_next = M_NUMBER;
          end else begin
            b_end_adv = 1'b1;
            case (b)
              "'":     mode_next = M_STRING;
              "-":     mode_next = M_MINUS;
              "/":     mode_next = M_SLASH;
              "!":     mode_next = M_BANG;
              "<":     mode_next = M_LESS;
              ">":     mode_next = M_GREATER;
              "+":     begin b_valid = 1'b1; b_kind = sqlts_pkg::K_PLUS;      end
              "*":     begin b_valid = 1'b1; b_kind = sqlts_pkg::K_STAR;      end
              "=":     begin b_valid = 1'b1; b_kind = sqlts_pkg::K_EQUAL;     end
              "(":     begin b_valid = 1'b1; b_kind = sqlts_pkg::K_LPAREN;    end
              ")":     begin b_valid = 1'b1; b_kind = sqlts_pkg::K_RPAREN;    end
              ",":     begin b_valid = 1'b1; b_kind = sqlts_pkg::K_COMMA;     end
              ".":     begin b_valid = 1'b1; b_kind = sqlts_pkg::K_DOT;       end
              ";":     begin b_valid = 1'b1; b_kind = sqlts_pkg::K_SEMICOLON; end
              default: begin b_valid = 1'b1; b_kind = sqlts_pkg::K_INVALID;   end
            endcase
          end
        end
      end
    end
  end

  // Build the tokens and pack them to the front
  always_comb begin
    tok_a.token_kind   = a_kind;
    tok_a.start_offset = 32'(tok_off);
    tok_a.start_line   = 32'(tok_line);
    tok_a.start_column = 32'(tok_col);
    tok_a.end_offset   = a_end_adv ? 32'(adv_off)  : 32'(cur_off);
    tok_a.end_line     = a_end_adv ? 32'(adv_line) : 32'(cur_line);
    tok_a.end_column   = a_end_adv ? 32'(adv_col)  : 32'(cur_col);
    tok_a.last_of_run  = !b_valid;

    tok_b.token_kind   = b_kind;
    tok_b.start_offset = 32'(cur_off);
    tok_b.start_line   = 32'(cur_line);
    tok_b.start_column = 32'(cur_col);
    tok_b.end_offset   = b_end_adv ? 32'(adv_off)  : 32'(cur_off);
    tok_b.end_line     = b_end_adv ? 32'(adv_line) : 32'(cur_line);
    tok_b.end_column   = b_end_adv ? 32'(adv_col)  : 32'(cur_col);
    tok_b.last_of_run  = 1'b1;

    res0   = a_valid ? tok_a : tok_b;
    res1   = tok_b;
    push_n = {1'b0, a_valid} + {1'b0, b_valid};
  end

  // Queue handshake
  assign byte_ready  = count <= sqlts_pkg::qcount_t'(sqlts_pkg::QUEUE_DEPTH - 2);
  assign token_valid = count != '0;
  assign token_data  = queue[rd_ptr];
  assign push        = byte_valid && byte_ready;
  assign pop         = token_valid && token_ready;

  // Scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      prefix   <= '0;
      wlen     <= '0;
      cur_off  <= '0;
      cur_line <= sqlts_pkg::loc_t'(1);
      cur_col  <= sqlts_pkg::loc_t'(1);
      tok_off  <= '0;
      tok_line <= sqlts_pkg::loc_t'(1);
      tok_col  <= sqlts_pkg::loc_t'(1);
    end else if (push) begin
      mode     <= mode_next;
      prefix   <= prefix_next;
      wlen     <= wlen_next;
      cur_off  <= cur_off_next;
      cur_line <= cur_line_next;
      cur_col  <= cur_col_next;
      tok_off  <= tok_off_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
    end
  end

  // Token queue pointers and storage
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + sqlts_pkg::qptr_t'(push_n);
      if (pop) rd_ptr <= rd_ptr + sqlts_pkg::qptr_t'(1);
      count <= count + (push ? sqlts_pkg::qcount_t'(push_n) : sqlts_pkg::qcount_t'(0))
               - sqlts_pkg::qcount_t'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_n != 2'd0) queue[wr_ptr] <= res0;
    if (push && push_n == 2'd2) queue[wr_ptr + sqlts_pkg::qptr_t'(1)] <= res1;
  end

endmodule

// File: dv/tb.sv
// Self-checking testbench for sql_token_scanner: byte stream in, located tokens checked out.
module tb;

  // Lexer states of the predictor
  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_STRING, SCAN_STRING_QUOTE, SCAN_MINUS,
    SCAN_SLASH, SCAN_BANG, SCAN_LESS, SCAN_GREATER, SCAN_LINE_COMMENT, SCAN_BLOCK,
    SCAN_BLOCK_STAR
  } scan_mode_t;

  // Predicts the tokens of each accepted request and checks the tokens that come out
  class token_scoreboard;
    string              keyword_names [sqlts_pkg::NUM_KEYWORDS];
    scan_mode_t         mode;
    logic [7:0]         word_prefix [6];
    int unsigned        word_len;
    sqlts_pkg::loc_t    cur_offset, cur_line, cur_column;
    sqlts_pkg::loc_t    tok_offset, tok_line, tok_column;
    sqlts_pkg::token_t  expected_tokens [$];
    sqlts_pkg::token_t  step_tokens [$];
    int unsigned        checked, mismatches;
    logic [63:0]        kinds_seen;

    function new();
      keyword_names = '{"select", "from", "where", "insert", "into", "values", "create",
                        "table", "drop", "null", "and", "or", "not", "as", "order", "by",
                        "limit", "true", "false"};
      checked = 0;
      mismatches = 0;
      kinds_seen = '0;
      restart();
    endfunction

    function void restart();
      mode = SCAN_IDLE;
      foreach (word_prefix[i]) word_prefix[i] = 8'h00;
      word_len = 0;
      cur_offset = '0;
      cur_line = sqlts_pkg::loc_t'(1);
      cur_column = sqlts_pkg::loc_t'(1);
      tok_offset = '0;
      tok_line = sqlts_pkg::loc_t'(1);
      tok_column = sqlts_pkg::loc_t'(1);
    endfunction

    // Counters stick at all ones
    function sqlts_pkg::loc_t bump(sqlts_pkg::loc_t v);
      return (v == {sqlts_pkg::LOCATION_BITS{1'b1}}) ? v : v + sqlts_pkg::loc_t'(1);
    endfunction

    function void advance(logic [7:0] b);
      cur_offset = bump(cur_offset);
      if (b == "\n") begin
        cur_line = bump(cur_line);
        cur_column = sqlts_pkg::loc_t'(1);
      end else cur_column = bump(cur_column);
    endfunction

    function void mark_start();
      tok_offset = cur_offset;
      tok_line = cur_line;
      tok_column = cur_column;
    endfunction

    function void emit(logic [5:0] kind);
      sqlts_pkg::token_t t;
      t.token_kind   = kind;
      t.start_offset = 32'(tok_offset);
      t.end_offset   = 32'(cur_offset);
      t.start_line   = 32'(tok_line);
      t.start_column = 32'(tok_column);
      t.end_line     = 32'(cur_line);
      t.end_column   = 32'(cur_column);
      t.last_of_run  = 1'b0;
      step_tokens = {step_tokens, t};
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Keep a lowercased six-byte prefix and a length that stops at seven
    function void add_word_byte(logic [7:0] c);
      logic [7:0] lc;
      lc = c;
      if (lc >= "A" && lc <= "Z") lc = lc + 8'd32;
      if (word_len < 6) word_prefix[word_len] = lc;
      if (word_len < 7) word_len++;
    endfunction

    function logic [5:0] word_kind();
      bit same;
      if (word_len > 6) return sqlts_pkg::K_IDENT;
      for (int k = 0; k < sqlts_pkg::NUM_KEYWORDS; k++) begin
        same = (keyword_names[k].len() == word_len);
        for (int i = 0; i < word_len && same; i++)
          same = (keyword_names[k][i] == word_prefix[i]);
        if (same) return sqlts_pkg::K_KEYWORD_BASE + 6'(k);
      end
      return sqlts_pkg::K_IDENT;
    endfunction

    // A byte seen between tokens
    function void start_token(logic [7:0] b);
      if (is_blank(b)) begin
        advance(b);
        return;
      end
      mark_start();
      advance(b);
      if (is_letter(b)) begin
        foreach (word_prefix[i]) word_prefix[i] = 8'h00;
        word_len = 0;
        add_word_byte(b);
        mode = SCAN_WORD;
        return;
      end
      if (is_digit(b)) begin
        mode = SCAN_NUMBER;
        return;
      end
      case (b)
        "'": mode = SCAN_STRING;
        "-": mode = SCAN_MINUS;
        "/": mode = SCAN_SLASH;
        "!": mode = SCAN_BANG;
        "<": mode = SCAN_LESS;
        ">": mode = SCAN_GREATER;
        "+": emit(sqlts_pkg::K_PLUS);
        "*": emit(sqlts_pkg::K_STAR);
        "=": emit(sqlts_pkg::K_EQUAL);
        "(": emit(sqlts_pkg::K_LPAREN);
        ")": emit(sqlts_pkg::K_RPAREN);
        ",": emit(sqlts_pkg::K_COMMA);
        ".": emit(sqlts_pkg::K_DOT);
        ";": emit(sqlts_pkg::K_SEMICOLON);
        default: emit(sqlts_pkg::K_INVALID);
      endcase
    endfunction

    // Lookahead byte decided the pending token; the byte itself starts over
    function void close_and_restart(logic [5:0] kind, logic [7:0] b);
      emit(kind);
      mode = SCAN_IDLE;
      start_token(b);
    endfunction

    function void scan_byte(logic [7:0] b);
      case (mode)
        SCAN_WORD: begin
          if (is_letter(b) || is_digit(b)) begin
            add_word_byte(b);
            advance(b);
          end else close_and_restart(word_kind(), b);
        end
        SCAN_NUMBER: begin
          if (is_digit(b)) advance(b);
          else close_and_restart(sqlts_pkg::K_INTEGER, b);
        end
        SCAN_STRING: begin
          advance(b);
          if (b == "'") mode = SCAN_STRING_QUOTE;
        end
        SCAN_STRING_QUOTE: begin
          if (b == "'") begin
            advance(b);
            mode = SCAN_STRING;
          end else close_and_restart(sqlts_pkg::K_STRING, b);
        end
        SCAN_MINUS: begin
          if (b == "-") begin
            advance(b);
            mode = SCAN_LINE_COMMENT;
          end else close_and_restart(sqlts_pkg::K_MINUS, b);
        end
        SCAN_SLASH: begin
          if (b == "*") begin
            advance(b);
            mode = SCAN_BLOCK;
          end else close_and_restart(sqlts_pkg::K_SLASH, b);
        end
        SCAN_BANG: begin
          if (b == "=") begin
            advance(b);
            emit(sqlts_pkg::K_NOT_EQUAL);
            mode = SCAN_IDLE;
          end else close_and_restart(sqlts_pkg::K_INVALID, b);
        end
        SCAN_LESS: begin
          if (b == "=" || b == ">") begin
            advance(b);
            emit(b == "=" ? sqlts_pkg::K_LESS_EQUAL : sqlts_pkg::K_NOT_EQUAL);
            mode = SCAN_IDLE;
          end else close_and_restart(sqlts_pkg::K_LESS, b);
        end
        SCAN_GREATER: begin
          if (b == "=") begin
            advance(b);
            emit(sqlts_pkg::K_GREATER_EQUAL);
            mode = SCAN_IDLE;
          end else close_and_restart(sqlts_pkg::K_GREATER, b);
        end
        SCAN_LINE_COMMENT: begin
          if (b == "\n") begin
            mode = SCAN_IDLE;
            start_token(b);
          end else advance(b);
        end
        SCAN_BLOCK: begin
          advance(b);
          if (b == "*") mode = SCAN_BLOCK_STAR;
        end
        SCAN_BLOCK_STAR: begin
          advance(b);
          if (b == "/") mode = SCAN_IDLE;
          else if (b != "*") mode = SCAN_BLOCK;
        end
        default: begin
          mode = SCAN_IDLE;
          start_token(b);
        end
      endcase
    endfunction

    // End of text: flush the pending token, add the end token unless a block comment is open
    function void flush_text();
      bit give_end;
      give_end = 1'b1;
      case (mode)
        SCAN_WORD:         emit(word_kind());
        SCAN_NUMBER:       emit(sqlts_pkg::K_INTEGER);
        SCAN_STRING:       emit(sqlts_pkg::K_INVALID);
        SCAN_STRING_QUOTE: emit(sqlts_pkg::K_STRING);
        SCAN_MINUS:        emit(sqlts_pkg::K_MINUS);
        SCAN_SLASH:        emit(sqlts_pkg::K_SLASH);
        SCAN_BANG:         emit(sqlts_pkg::K_INVALID);
        SCAN_LESS:         emit(sqlts_pkg::K_LESS);
        SCAN_GREATER:      emit(sqlts_pkg::K_GREATER);
        SCAN_BLOCK, SCAN_BLOCK_STAR: begin
          emit(sqlts_pkg::K_COMMENT_ERROR);
          give_end = 1'b0;
        end
        default: ;
      endcase
      if (give_end) begin
        mark_start();
        emit(sqlts_pkg::K_END);
      end
      restart();
    endfunction

    function void note_request(sqlts_pkg::byte_req_t r);
      sqlts_pkg::token_t t;
      step_tokens.delete();
      if (r.end_of_input) flush_text();
      else scan_byte(r.byte_value);
      foreach (step_tokens[i]) begin
        t = step_tokens[i];
        t.last_of_run = (i == step_tokens.size() - 1);
        expected_tokens = {expected_tokens, t};
      end
    endfunction

    function string describe(sqlts_pkg::token_t t);
      return $sformatf("kind %0d offsets [%0d,%0d) from %0d:%0d to %0d:%0d last %0b",
                       t.token_kind, t.start_offset, t.end_offset, t.start_line,
                       t.start_column, t.end_line, t.end_column, t.last_of_run);
    endfunction

    function void check_token(sqlts_pkg::token_t got);
      sqlts_pkg::token_t want;
      string             diff;
      checked++;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("token with none expected: %s", describe(got));
        return;
      end
      want = expected_tokens.pop_front();
      diff = "";
      if (got.token_kind !== want.token_kind) diff = {diff, " token_kind"};
      if (got.start_offset !== want.start_offset) diff = {diff, " start_offset"};
      if (got.end_offset !== want.end_offset) diff = {diff, " end_offset"};
      if (got.start_line !== want.start_line) diff = {diff, " start_line"};
      if (got.start_column !== want.start_column) diff = {diff, " start_column"};
      if (got.end_line !== want.end_line) diff = {diff, " end_line"};
      if (got.end_column !== want.end_column) diff = {diff, " end_column"};
      if (got.last_of_run !== want.last_of_run) diff = {diff, " last_of_run"};
      if (diff != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("token mismatch in%s", diff);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end else kinds_seen[got.token_kind] = 1'b1;
    endfunction
  endclass

  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT_TOKEN = 150;
  localparam int RANDOM_ITEMS  = 1250;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 byte_valid = 1'b0;
  logic                 byte_ready;
  sqlts_pkg::byte_req_t byte_data = '0;
  logic                 token_valid;
  logic                 token_ready = 1'b0;
  sqlts_pkg::token_t    token_data;

  token_scoreboard      scanner_sb;
  sqlts_pkg::byte_req_t text_queue [$];
  int unsigned          bytes_sent = 0;
  int unsigned          ends_sent = 0;
  int unsigned          idle_cycles = 0;

  sql_token_scanner i_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_data   (byte_data),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_data  (token_data)
  );

  always #2 clk = ~clk;

  // Handshake monitor, prediction, checking and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && byte_ready) scanner_sb.note_request(byte_data);
      if (token_valid && token_ready) scanner_sb.check_token(token_data);
      if ((byte_valid && byte_ready) || (token_valid && token_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Mostly short gaps, a few long ones, none at all while steady
  function automatic int gap_cycles(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    sqlts_pkg::byte_req_t r;
    r.byte_value = b;
    r.end_of_input = 1'b0;
    text_queue = {text_queue, r};
  endfunction

  // Byte field is don't-care on an end request, so it is random
  function automatic void add_end();
    sqlts_pkg::byte_req_t r;
    r.byte_value = 8'($urandom_range(0, 255));
    r.end_of_input = 1'b1;
    text_queue = {text_queue, r};
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_from_set(string set, int n);
    for (int i = 0; i < n; i++) add_byte(set[$urandom_range(0, set.len() - 1)]);
  endfunction

  function automatic logic [7:0] word_char(bit first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  function automatic void add_blank();
    case ($urandom_range(0, 5))
      0: add_byte(" ");
      1: add_byte(8'h09);
      2: add_byte(8'h0A);
      3: add_byte(8'h0B);
      4: add_byte(8'h0C);
      default: add_byte(8'h0D);
    endcase
  endfunction

  function automatic void add_operator();
    case ($urandom_range(0, 16))
      0: add_text("+");    1: add_text("-");    2: add_text("*");    3: add_text("/");
      4: add_text("=");    5: add_text("!=");   6: add_text("<>");   7: add_text("<");
      8: add_text("<=");   9: add_text(">");   10: add_text(">=");  11: add_text("(");
      12: add_text(")");  13: add_text(",");   14: add_text(".");   15: add_text(";");
      default: add_text("!");
    endcase
  endfunction

  // One lexical piece of SQL-like text, sometimes noise or a broken ending
  function automatic void add_fragment();
    int         pick;
    int         n;
    string      s;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      // keyword in random case
      s = scanner_sb.keyword_names[$urandom_range(0, sqlts_pkg::NUM_KEYWORDS - 1)];
      for (int i = 0; i < s.len(); i++) begin
        c = s[i];
        if ($urandom_range(0, 1)) c = c - 8'd32;
        add_byte(c);
      end
    end else if (pick < 34) begin
      n = $urandom_range(1, 9);
      for (int i = 0; i < n; i++) add_byte(word_char(i == 0));
    end else if (pick < 42) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) add_byte(8'("0" + $urandom_range(0, 9)));
    end else if (pick < 50) begin
      // quoted string, doubled quotes and newlines inside
      add_byte("'");
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: add_text("''");
          3, 4: add_byte(8'h0A);
          default: begin
            c = 8'($urandom_range(32, 126));
            if (c == "'") add_text("''");
            else add_byte(c);
          end
        endcase
      end
      add_byte("'");
    end else if (pick < 66) add_operator();
    else if (pick < 76) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) add_blank();
    end else if (pick < 81) begin
      add_text("--");
      add_from_set(" a-*/'", $urandom_range(0, 6));
      if ($urandom_range(0, 4) != 0) add_byte(8'h0A);
    end else if (pick < 86) begin
      add_text("/*");
      add_from_set(" a*\n/'", $urandom_range(0, 8));
      add_text("*/");
    end else if (pick < 95) add_byte(8'($urandom_range(0, 255)));
    else if (pick < 97) begin
      add_text("'ab");
      add_end();
    end else if (pick < 99) begin
      add_text("/* x");
      add_end();
    end else begin
      add_text("/**");
      add_end();
    end
  endfunction

  // Extremes of the byte, lone bang, doubled quote, open string, open comment, line comment
  function automatic void build_directed();
    add_end();
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("!");
    add_end();
    add_text("SeLeCt 'a''b");
    add_end();
    add_text("/*");
    add_end();
    add_text("--");
    add_end();
  endfunction

  function automatic void build_random();
    int target;
    target = text_queue.size() + RANDOM_ITEMS;
    while (text_queue.size() < target) begin
      add_fragment();
      if ($urandom_range(0, 1)) add_blank();
      if ($urandom_range(0, 39) == 0) add_end();
    end
    add_end();
  endfunction

  task automatic send_request(input sqlts_pkg::byte_req_t r);
    byte_valid <= 1'b1;
    byte_data <= r;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
  endtask

  // Token consumer with random stalls and one long hold-off
  initial begin : token_sink
    int unsigned taken;
    int          n;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      token_ready <= 1'b1;
      @(posedge clk);
      while (!(token_valid && token_ready)) @(posedge clk);
      taken++;
      if (taken == HOLD_AT_TOKEN) n = HOLD_CYCLES;
      else n = gap_cycles((taken / 100) % 3 == 1);
      if (n > 0) begin
        token_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Reset, byte stream, drain and verdict
  initial begin : byte_source
    int gap;
    scanner_sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    build_directed();
    build_random();
    foreach (text_queue[i]) begin
      send_request(text_queue[i]);
      if (text_queue[i].end_of_input) ends_sent++;
      else bytes_sent++;
      gap = gap_cycles((i / 150) % 3 == 2);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    byte_valid <= 1'b0;
    // let the monitor record the last request before looking at the backlog
    @(posedge clk);
    while (scanner_sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("sent %0d text bytes and %0d end marks, checked %0d tokens",
             bytes_sent, ends_sent, scanner_sb.checked);
    $display("distinct token kinds matched: %0d, mismatches: %0d",
             $countones(scanner_sb.kinds_seen), scanner_sb.mismatches);
    if (scanner_sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
